>>> rtl/cdn_pkg.sv
// ----------------------------------------------------------------------------
// cdn_pkg: civil date day count types and constants
// Transfer types, pipeline stage records and calendar tables shared by the
// day count unit.
// ----------------------------------------------------------------------------
package cdn_pkg;

  localparam logic [13:0] YEAR_BASE     = 14'd1970;
  localparam logic [13:0] YEAR_LAST     = 14'd9999;
  localparam logic [12:0] RECIP_100     = 13'd5243;
  localparam int          RECIP_SHIFT   = 19;
  localparam logic [6:0]  HUNDRED       = 7'd100;
  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
  localparam logic [11:0] LEAPS_BASE    = 12'd477;
  localparam logic [3:0]  MONTH_FEB     = 4'd2;
  localparam logic [3:0]  MONTH_DEC     = 4'd12;
  localparam logic [3:0]  MONTH_JAN     = 4'd1;

  typedef struct packed {
    logic [4:0]  in_day;
    logic [3:0]  in_month;
    logic [13:0] in_year;
  } cdn_in_t;

  typedef struct packed {
    logic [21:0] day_number;
    logic        is_valid;
    logic        is_leap;
    logic [4:0]  month_length;
    logic [4:0]  next_day;
    logic [3:0]  next_month;
    logic [13:0] next_year;
  } cdn_out_t;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [26:0] prod_y;
    logic [26:0] prod_n;
    logic        month_ok;
    logic        year_ok;
    logic [4:0]  month_base;
    logic [8:0]  days_before;
  } cdn_s1_t;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic        month_ok;
    logic        year_ok;
    logic [4:0]  month_base;
    logic [8:0]  days_before;
    logic [11:0] leaps;
    logic [12:0] year_off;
    logic        leap;
  } cdn_s2_t;

  typedef struct packed {
    logic [21:0] year_days;
    logic [21:0] rest_days;
    logic        ok;
    logic        leap;
    logic [4:0]  month_length;
    logic [4:0]  next_day;
    logic [3:0]  next_month;
    logic [13:0] next_year;
  } cdn_s3_t;

  function automatic logic [4:0] month_days(input logic [3:0] m);
    logic [4:0] r;
    case (m)
      4'd1:    r = 5'd31;
      4'd2:    r = 5'd28;
      4'd3:    r = 5'd31;
      4'd4:    r = 5'd30;
      4'd5:    r = 5'd31;
      4'd6:    r = 5'd30;
      4'd7:    r = 5'd31;
      4'd8:    r = 5'd31;
      4'd9:    r = 5'd30;
      4'd10:   r = 5'd31;
      4'd11:   r = 5'd30;
      4'd12:   r = 5'd31;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/civil_date_day_count_and_next_unit.sv
// Pipeline: input transfer to result valid passes through four register
// stages (reciprocal multiply, remainder and leap count, year days
// and next date, final sum).
// Throughput: one date per cycle; a stall holds only stages that are full.
// Reset: synchronous active-low rst_n clears every stage valid bit.
// ----------------------------------------------------------------------------
// civil_date_day_count_and_next_unit: Gregorian date to day number
// Converts a civil date to its day count, with 1970-01-01 as day 1, and
// gives the leap flag, month length and the following date.
// ----------------------------------------------------------------------------
module civil_date_day_count_and_next_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  cdn_pkg::cdn_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output cdn_pkg::cdn_out_t out_data
);
  import cdn_pkg::*;

  logic     s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  cdn_s1_t  s1_r, s1_nxt;
  cdn_s2_t  s2_r, s2_nxt;
  cdn_s3_t  s3_r, s3_nxt;
  cdn_out_t s4_r, s4_nxt;
  logic     rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !s4_vld_r || !out_stall;
  assign rdy3     = !s3_vld_r || rdy4;
  assign rdy2     = !s2_vld_r || rdy3;
  assign rdy1     = !s1_vld_r || rdy2;
  assign in_stall = !rdy1;
  assign out_valid = s4_vld_r;
  assign out_data  = s4_r;

  // stage 1: reciprocal multiply by 1/100, table lookups, range checks
  logic [13:0] yr_prev_in;
  always_comb begin
    yr_prev_in           = in_data.in_year - 14'd1;
    s1_nxt.day           = in_data.in_day;
    s1_nxt.month         = in_data.in_month;
    s1_nxt.year          = in_data.in_year;
    s1_nxt.prod_y        = 27'(in_data.in_year) * 27'(RECIP_100);
    s1_nxt.prod_n        = 27'(yr_prev_in) * 27'(RECIP_100);
    s1_nxt.month_ok      = (in_data.in_month >= MONTH_JAN) && (in_data.in_month <= MONTH_DEC);
    s1_nxt.year_ok       = (in_data.in_year >= YEAR_BASE) && (in_data.in_year <= YEAR_LAST);
    s1_nxt.month_base    = month_days(in_data.in_month);
    s1_nxt.days_before   = days_before(in_data.in_month);
  end

  // stage 2: century remainder, leap flag, leap count up to previous year
  logic [7:0]  q100_y, q100_n;
  logic [13:0] yr_prev, hund_y;
  logic        rem0;
  always_comb begin
    q100_y  = s1_r.prod_y[RECIP_SHIFT +: 8];
    q100_n  = s1_r.prod_n[RECIP_SHIFT +: 8];
    yr_prev = s1_r.year - 14'd1;
    hund_y  = 14'(q100_y) * 14'(HUNDRED);
    rem0    = (hund_y == s1_r.year);
    s2_nxt.day         = s1_r.day;
    s2_nxt.month       = s1_r.month;
    s2_nxt.year        = s1_r.year;
    s2_nxt.month_ok    = s1_r.month_ok;
    s2_nxt.year_ok     = s1_r.year_ok;
    s2_nxt.month_base  = s1_r.month_base;
    s2_nxt.days_before = s1_r.days_before;
    s2_nxt.leaps       = yr_prev[13:2] - 12'(q100_n) + 12'(q100_n[7:2]);
    s2_nxt.year_off    = 13'(s1_r.year - YEAR_BASE);
    s2_nxt.leap        = (s1_r.year[1:0] == 2'd0) && (!rem0 || (q100_y[1:0] == 2'd0));
  end

  // stage 3: year days, month length, validity, following date
  logic [4:0] mlen;
  logic       ok, roll, feb_extra, late_extra;
  always_comb begin
    feb_extra  = (s2_r.month == MONTH_FEB) && s2_r.leap;
    late_extra = (s2_r.month > MONTH_FEB) && s2_r.leap;
    mlen       = s2_r.month_ok ? s2_r.month_base + 5'(feb_extra) : 5'd0;
    ok         = s2_r.month_ok && s2_r.year_ok && (s2_r.day != 5'd0) && (s2_r.day <= mlen);
    roll       = (s2_r.day >= mlen);
    s3_nxt.year_days    = 22'(s2_r.year_off) * 22'(DAYS_PER_YEAR);
    s3_nxt.rest_days    = 22'(s2_r.leaps) - 22'(LEAPS_BASE) + 22'(s2_r.days_before)
                          + 22'(late_extra) + 22'(s2_r.day);
    s3_nxt.ok           = ok;
    s3_nxt.leap         = s2_r.leap;
    s3_nxt.month_length = mlen;
    s3_nxt.next_day     = 5'd0;
    s3_nxt.next_month   = 4'd0;
    s3_nxt.next_year    = 14'd0;
    if (ok) begin
      if (!roll) begin
        s3_nxt.next_day   = s2_r.day + 5'd1;
        s3_nxt.next_month = s2_r.month;
        s3_nxt.next_year  = s2_r.year;
      end else if (s2_r.month == MONTH_DEC) begin
        s3_nxt.next_day   = 5'd1;
        s3_nxt.next_month = MONTH_JAN;
        s3_nxt.next_year  = s2_r.year + 14'd1;
      end else begin
        s3_nxt.next_day   = 5'd1;
        s3_nxt.next_month = s2_r.month + 4'd1;
        s3_nxt.next_year  = s2_r.year;
      end
    end
  end

  // stage 4: final sum, day number zero for an invalid date
  always_comb begin
    s4_nxt.day_number   = s3_r.ok ? s3_r.year_days + s3_r.rest_days : 22'd0;
    s4_nxt.is_valid     = s3_r.ok;
    s4_nxt.is_leap      = s3_r.leap;
    s4_nxt.month_length = s3_r.month_length;
    s4_nxt.next_day     = s3_r.next_day;
    s4_nxt.next_month   = s3_r.next_month;
    s4_nxt.next_year    = s3_r.next_year;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      if (rdy1) s1_vld_r <= in_valid;
      if (rdy2) s2_vld_r <= s1_vld_r;
      if (rdy3) s3_vld_r <= s2_vld_r;
      if (rdy4) s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1_r <= s1_nxt;
    if (rdy2) s2_r <= s2_nxt;
    if (rdy3) s3_r <= s3_nxt;
    if (rdy4) s4_r <= s4_nxt;
  end

`ifndef ASSERT_OFF
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");
  a_no_stall_flows: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output drains");
  a_valid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_valid |-> (out_data.day_number != 22'd0)
      && (out_data.next_day != 5'd0) && (out_data.next_month != 4'd0)
      && (out_data.next_month <= MONTH_DEC))
    else $error("valid date with bad day number or next date");
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_valid |-> (out_data.day_number == 22'd0)
      && (out_data.next_day == 5'd0) && (out_data.next_month == 4'd0)
      && (out_data.next_year == 14'd0))
    else $error("invalid date with nonzero result");
`endif

endmodule

>>> bench/civil_date_day_count_and_next_unit_test.sv
// ----------------------------------------------------------------------------
// civil_date_day_count_and_next_unit_test: self-checking bench for the date unit
// Sends civil dates through the valid/stall input channel and compares every
// result with a day count and next-date model kept in the bench. A directed
// set covers the calendar edges. A random set follows, made mostly of real
// dates with some noise. Both channels idle at random.
// ----------------------------------------------------------------------------
module civil_date_day_count_and_next_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cdn_pkg::*;

  localparam int unsigned RANDOM_DATES = 400;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid = 1'b0;
  logic     in_stall;
  cdn_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  cdn_out_t out_data;

  cdn_in_t     date_queue[$];
  cdn_out_t    due_results[$];
  bit          in_taken;
  bit          in_calm;
  bit          out_calm;
  int unsigned in_gap;
  int unsigned out_hold;
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned checked_count;
  int unsigned valid_count;
  int unsigned month_wraps;
  int unsigned year_wraps;

  civil_date_day_count_and_next_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit is_leap_year(input int unsigned y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  // common-year length of month 1..12
  function automatic int unsigned base_month_len(input int unsigned m);
    if (m == MONTH_FEB) return 28;
    return 30 + ((m + m / 8) % 2);
  endfunction

  function automatic int unsigned leaps_through(input int unsigned n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  function automatic cdn_out_t civil_day_count(input cdn_in_t d);
    cdn_out_t    r;
    int unsigned dd;
    int unsigned mm;
    int unsigned yy;
    int unsigned mlen;
    int unsigned ahead;
    bit          leap;
    bit          ok;
    dd = 32'(d.in_day);
    mm = 32'(d.in_month);
    yy = 32'(d.in_year);
    r = '0;
    leap = is_leap_year(yy);
    mlen = 0;
    if (mm >= 1 && mm <= 12) mlen = base_month_len(mm) + ((mm == MONTH_FEB && leap) ? 1 : 0);
    ok = dd >= 1 && dd <= mlen && yy >= YEAR_BASE && yy <= YEAR_LAST;
    r.is_leap = leap;
    r.month_length = 5'(mlen);
    if (ok) begin
      ahead = 0;
      for (int unsigned k = 1; k < mm; k++) ahead += base_month_len(k);
      if (mm > MONTH_FEB && leap) ahead++;
      r.is_valid = 1'b1;
      r.day_number = 22'(365 * (yy - YEAR_BASE) + leaps_through(yy - 1)
                         - leaps_through(YEAR_BASE - 1) + ahead + dd);
      r.next_day = 5'(dd + 1);
      r.next_month = 4'(mm);
      r.next_year = 14'(yy);
      if (dd == mlen) begin
        r.next_day = 5'd1;
        if (mm == MONTH_DEC) begin
          r.next_month = MONTH_JAN;
          r.next_year = 14'(yy + 1);
        end else begin
          r.next_month = 4'(mm + 1);
        end
      end
    end
    return r;
  endfunction

  function automatic cdn_in_t pick_date();
    cdn_in_t     v;
    int unsigned y;
    int unsigned m;
    int unsigned lim;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 12) begin
      v.in_day = 5'($urandom_range(0, 31));
      v.in_month = 4'($urandom_range(0, 15));
      v.in_year = 14'($urandom_range(0, 16383));
      return v;
    end
    case ($urandom_range(0, 5))
      0:       y = $urandom_range(1970, 1980);
      1:       y = $urandom_range(9990, 9999);
      2:       y = 100 * $urandom_range(20, 99);
      default: y = $urandom_range(1970, 9999);
    endcase
    m = $urandom_range(1, 12);
    lim = base_month_len(m) + ((m == MONTH_FEB && is_leap_year(y)) ? 1 : 0);
    v.in_year = 14'(y);
    v.in_month = 4'(m);
    if (sel < 20) v.in_day = 5'(lim + 1);
    else if (sel < 50) v.in_day = 5'(lim - $urandom_range(0, 1));
    else v.in_day = 5'($urandom_range(1, lim));
    return v;
  endfunction

  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_date(input int unsigned d, input int unsigned m, input int unsigned y);
    cdn_in_t v;
    v.in_day = 5'(d);
    v.in_month = 4'(m);
    v.in_year = 14'(y);
    date_queue.push_back(v);
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap = in_gap - 1;
      end else if (date_queue.size() != 0) begin
        in_data <= date_queue.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
        in_gap = in_calm ? 0 : idle_span();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (out_hold != 0) begin
      out_stall <= 1'b1;
      out_hold = out_hold - 1;
    end else if (!out_calm && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      out_hold = idle_span();
    end else begin
      out_stall <= 1'b0;
    end
    if ($urandom_range(0, 255) == 0) out_calm = !out_calm;
  end

  always @(posedge clk) begin
    cdn_out_t want;
    in_taken = rst_n && in_valid === 1'b1 && in_stall === 1'b0;
    if (in_taken) due_results.push_back(civil_day_count(in_data));
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (due_results.size() == 0) begin
        $error("result transfer with no date pending");
        fail_count++;
      end else begin
        want = due_results.pop_front();
        check_field("day_number", want.day_number, out_data.day_number);
        check_field("is_valid", want.is_valid, out_data.is_valid);
        check_field("is_leap", want.is_leap, out_data.is_leap);
        check_field("month_length", want.month_length, out_data.month_length);
        check_field("next_day", want.next_day, out_data.next_day);
        check_field("next_month", want.next_month, out_data.next_month);
        check_field("next_year", want.next_year, out_data.next_year);
        checked_count++;
        if (want.is_valid) valid_count++;
        if (want.is_valid && want.next_day == 1) month_wraps++;
        if (want.is_valid && want.next_day == 1 && want.next_month == MONTH_JAN) year_wraps++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               due_results.size());
      $display("civil_date_day_count_and_next_unit_test failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;

    push_date(1, 1, 1970);
    push_date(31, 12, 9999);
    push_date(31, 12, 1969);
    push_date(1, 1, 10000);
    push_date(0, 0, 0);
    push_date(31, 15, 16383);
    push_date(0, 5, 2020);
    push_date(31, 4, 2021);
    push_date(30, 4, 2021);
    push_date(29, 2, 2000);
    push_date(29, 2, 2100);
    push_date(28, 2, 2100);
    push_date(29, 2, 2024);
    push_date(28, 2, 2024);
    push_date(28, 2, 2023);
    push_date(29, 2, 2023);
    push_date(15, 0, 2000);
    push_date(15, 13, 2000);
    push_date(31, 12, 1999);
    push_date(31, 1, 1970);
    push_date(30, 6, 5000);
    push_date(31, 10, 8888);
    push_date(10, 7, 16000);
    push_date(29, 2, 9996);
    for (int unsigned i = 0; i < RANDOM_DATES; i++) date_queue.push_back(pick_date());

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    wait (date_queue.size() == 0 && !in_valid);
    wait (due_results.size() == 0);
    repeat (20) @(posedge clk);

    $display("checked %0d results: %0d valid dates, %0d month and %0d year rollovers",
             checked_count, valid_count, month_wraps, year_wraps);
    if (fail_count == 0) begin
      $display("civil_date_day_count_and_next_unit_test passed");
    end else begin
      $display("civil_date_day_count_and_next_unit_test failed");
    end
    $finish;
  end

endmodule
